// ----- rtl/core/cla_pkg.sv -----
// Shared types, sizes and codes for the call latency aggregator.
// Used by cla_front, cla_back and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package cla_pkg;

  localparam int START_ENTRIES = 256;
  localparam int GROUP_ENTRIES = 256;
  localparam int START_IDX_W = (START_ENTRIES > 1) ? $clog2(START_ENTRIES) : 1;
  localparam int GROUP_IDX_W = (GROUP_ENTRIES > 1) ? $clog2(GROUP_ENTRIES) : 1;
  // scan counter holds the depth itself, so one bit more than the wider index
  localparam int SCAN_W = ((START_IDX_W > GROUP_IDX_W) ? START_IDX_W : GROUP_IDX_W) + 1;
  localparam int CFG_IDX_W = 8;

  typedef enum logic [1:0] {
    OP_ENTER  = 2'd0,
    OP_EXIT   = 2'd1,
    OP_READ   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FILTERED = 2'd1,
    STAT_MISS     = 2'd2,
    STAT_FULL     = 2'd3
  } stat_t;

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GROUP  = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_SCAN,
    S_START_WR,
    S_TOTAL_SCAN,
    S_TOTAL_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] thread_id;
    logic [31:0] call_number;
    logic [63:0] group_id;
    logic [63:0] ancestor_group;
    logic [63:0] timestamp_ns;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] this_latency;
    logic [63:0] call_count;
    logic [63:0] latency_sum;
  } out_item_t;

  // classified transaction handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     filtered;
  } job_t;

  typedef struct packed {
    logic [31:0] thread_id;
    logic [31:0] call_number;
    logic [63:0] start_time;
    logic [63:0] group_id;
    logic [63:0] stamp;
  } start_ent_t;

  typedef struct packed {
    logic [63:0] group_id;
    logic [31:0] call_number;
    logic [63:0] event_count;
    logic [63:0] latency_total;
  } total_ent_t;

endpackage
`default_nettype wire

// ----- rtl/core/cla_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module cla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/cla_front.sv -----
// Front end: accepts input transactions, applies the ancestor filter and
// queues classified jobs for the back end. Holds the configuration registers.
// Depends on cla_pkg.
`timescale 1ns / 1ps
`default_nettype none
module cla_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire cla_pkg::in_item_t          in_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [cla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                cfg_data,
  output logic                            job_valid,
  input  wire logic                       job_pop,
  output cla_pkg::job_t                   job
);

  logic        filter_en_r;
  logic [63:0] target_r;
  cla_pkg::job_t q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        push_ok;
  cla_pkg::job_t job_in;

  assign cfg_ready = 1'b1;

  // take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_en_r <= 1'b1;
      target_r    <= 64'd0;
    end else if (cfg_valid) begin
      if (cfg_index == cla_pkg::CFG_FILTER_ENABLE) filter_en_r <= cfg_data[0];
      if (cfg_index == cla_pkg::CFG_TARGET_GROUP)  target_r    <= cfg_data;
    end
  end

  // classify enter items against the target group
  always_comb begin
    job_in.item     = in_data;
    job_in.filtered = filter_en_r &&
                      !(in_data.ancestor_group != 64'd0 && in_data.ancestor_group == target_r);
  end

  assign in_full   = (count_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[rd_ptr_r];

  // two-entry job queue
  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (job_pop && job_valid) rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push_ok} - {1'b0, job_pop && job_valid};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/cla_back.sv -----
// Back end: scans the start and aggregate stores one entry per cycle,
// updates them and holds the result register. Depends on cla_pkg, cla_ram.
`timescale 1ns / 1ps
`default_nettype none
module cla_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_pop,
  input  wire cla_pkg::job_t     job,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output cla_pkg::out_item_t     out_data
);

  localparam int SIW = cla_pkg::START_IDX_W;
  localparam int GIW = cla_pkg::GROUP_IDX_W;
  localparam int SW  = cla_pkg::SCAN_W;
  localparam logic [SW-1:0] S_END = SW'(cla_pkg::START_ENTRIES);
  localparam logic [SW-1:0] G_END = SW'(cla_pkg::GROUP_ENTRIES);

  cla_pkg::state_t state_r, state_nxt;
  cla_pkg::job_t   job_r, job_nxt;
  logic [cla_pkg::START_ENTRIES-1:0] s_valid_r, s_valid_nxt;
  logic [cla_pkg::GROUP_ENTRIES-1:0] t_valid_r, t_valid_nxt;
  logic [63:0]   stamp_r, stamp_nxt;
  logic [SW-1:0] scan_addr_r, scan_addr_nxt, rd_idx_r, rd_idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt, old_r, old_nxt;
  logic [SW-1:0] hit_idx_r, hit_idx_nxt, free_idx_r, free_idx_nxt, old_idx_r, old_idx_nxt;
  logic [63:0]   old_stamp_r, old_stamp_nxt;
  logic [63:0]   hit_a_r, hit_a_nxt, hit_b_r, hit_b_nxt;
  logic [63:0]   key_group_r, key_group_nxt, lat_r, lat_nxt;
  cla_pkg::out_item_t res_pend_r, res_pend_nxt, res_r, res_nxt;
  logic          res_vld_r, res_vld_nxt;

  logic          issue, scan_done;
  logic          s_we, t_we;
  logic [SIW-1:0] s_waddr;
  logic [GIW-1:0] t_waddr;
  cla_pkg::start_ent_t s_wdata, s_rd;
  cla_pkg::total_ent_t t_wdata, t_rd;
  logic [SW-1:0]  slot;

  cla_ram #(.WIDTH($bits(cla_pkg::start_ent_t)), .DEPTH(cla_pkg::START_ENTRIES)) u_start_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(scan_addr_r[SIW-1:0]), .rdata(s_rd)
  );

  cla_ram #(.WIDTH($bits(cla_pkg::total_ent_t)), .DEPTH(cla_pkg::GROUP_ENTRIES)) u_total_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(scan_addr_r[GIW-1:0]), .rdata(t_rd)
  );

  assign out_empty = !res_vld_r;
  assign out_data  = res_r;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cla_pkg::S_IDLE;
      s_valid_r   <= '0;
      t_valid_r   <= '0;
      stamp_r     <= 64'd0;
      scan_addr_r <= '0;
      rd_pend_r   <= 1'b0;
      res_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s_valid_r   <= s_valid_nxt;
      t_valid_r   <= t_valid_nxt;
      stamp_r     <= stamp_nxt;
      scan_addr_r <= scan_addr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      res_vld_r   <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    rd_idx_r    <= rd_idx_nxt;
    hit_r       <= hit_nxt;
    free_r      <= free_nxt;
    old_r       <= old_nxt;
    hit_idx_r   <= hit_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_stamp_r <= old_stamp_nxt;
    hit_a_r     <= hit_a_nxt;
    hit_b_r     <= hit_b_nxt;
    key_group_r <= key_group_nxt;
    lat_r       <= lat_nxt;
    res_pend_r  <= res_pend_nxt;
    res_r       <= res_nxt;
  end

  assign issue = ((state_r == cla_pkg::S_START_SCAN) && (scan_addr_r < S_END)) ||
                 ((state_r == cla_pkg::S_TOTAL_SCAN) && (scan_addr_r < G_END));
  assign scan_done = !issue && !rd_pend_r;
  assign slot = hit_r ? hit_idx_r : (free_r ? free_idx_r : old_idx_r);

  // sequence one job through the stores
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    s_valid_nxt   = s_valid_r;
    t_valid_nxt   = t_valid_r;
    stamp_nxt     = stamp_r;
    scan_addr_nxt = scan_addr_r + {{(SW-1){1'b0}}, issue};
    rd_pend_nxt   = issue;
    rd_idx_nxt    = scan_addr_r;
    hit_nxt       = hit_r;
    free_nxt      = free_r;
    old_nxt       = old_r;
    hit_idx_nxt   = hit_idx_r;
    free_idx_nxt  = free_idx_r;
    old_idx_nxt   = old_idx_r;
    old_stamp_nxt = old_stamp_r;
    hit_a_nxt     = hit_a_r;
    hit_b_nxt     = hit_b_r;
    key_group_nxt = key_group_r;
    lat_nxt       = lat_r;
    res_pend_nxt  = res_pend_r;
    res_nxt       = res_r;
    res_vld_nxt   = res_vld_r && !out_pop;
    job_pop       = 1'b0;
    s_we          = 1'b0;
    t_we          = 1'b0;
    s_waddr       = slot[SIW-1:0];
    t_waddr       = hit_r ? hit_idx_r[GIW-1:0] : free_idx_r[GIW-1:0];
    s_wdata       = '{thread_id: job_r.item.thread_id, call_number: job_r.item.call_number,
                      start_time: job_r.item.timestamp_ns, group_id: job_r.item.group_id,
                      stamp: stamp_r};
    t_wdata       = '{group_id: key_group_r, call_number: job_r.item.call_number,
                      event_count: hit_a_r + 64'd1, latency_total: hit_b_r + lat_r};

    case (state_r)
      cla_pkg::S_IDLE: begin
        if (job_valid) begin
          job_pop       = 1'b1;
          job_nxt       = job;
          scan_addr_nxt = '0;
          rd_pend_nxt   = 1'b0;
          hit_nxt       = 1'b0;
          free_nxt      = 1'b0;
          old_nxt       = 1'b0;
          lat_nxt       = 64'd0;
          key_group_nxt = job.item.group_id;
          res_pend_nxt  = '{status: cla_pkg::STAT_DONE, this_latency: 64'd0,
                            call_count: 64'd0, latency_sum: 64'd0};
          case (cla_pkg::op_t'(job.item.op))
            cla_pkg::OP_ENTER: begin
              if (job.filtered) begin
                res_pend_nxt.status = cla_pkg::STAT_FILTERED;
                state_nxt = cla_pkg::S_RESULT;
              end else begin
                state_nxt = cla_pkg::S_START_SCAN;
              end
            end
            cla_pkg::OP_EXIT: state_nxt = cla_pkg::S_START_SCAN;
            cla_pkg::OP_READ: state_nxt = cla_pkg::S_TOTAL_SCAN;
            default:          state_nxt = cla_pkg::S_RESULT;
          endcase
        end
      end

      cla_pkg::S_START_SCAN: begin
        // look at the entry read last cycle
        if (rd_pend_r) begin
          if (s_valid_r[rd_idx_r[SIW-1:0]]) begin
            if (!hit_r && s_rd.thread_id == job_r.item.thread_id &&
                s_rd.call_number == job_r.item.call_number) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = rd_idx_r;
              hit_a_nxt   = s_rd.start_time;
              hit_b_nxt   = s_rd.group_id;
            end
            if (!old_r || s_rd.stamp < old_stamp_r) begin
              old_nxt       = 1'b1;
              old_idx_nxt   = rd_idx_r;
              old_stamp_nxt = s_rd.stamp;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (scan_done) begin
          if (job_r.item.op == cla_pkg::OP_ENTER) begin
            state_nxt = cla_pkg::S_START_WR;
          end else if (!hit_r) begin
            res_pend_nxt.status = cla_pkg::STAT_MISS;
            state_nxt = cla_pkg::S_RESULT;
          end else begin
            lat_nxt = (job_r.item.timestamp_ns > hit_a_r) ?
                      job_r.item.timestamp_ns - hit_a_r : 64'd0;
            key_group_nxt = hit_b_r;
            s_valid_nxt[hit_idx_r[SIW-1:0]] = 1'b0;
            scan_addr_nxt = '0;
            rd_pend_nxt   = 1'b0;
            hit_nxt       = 1'b0;
            free_nxt      = 1'b0;
            state_nxt     = cla_pkg::S_TOTAL_SCAN;
          end
        end
      end

      cla_pkg::S_START_WR: begin
        // store the start entry over a matching entry, else a free one, evicting the oldest when full
        s_we = 1'b1;
        s_valid_nxt[slot[SIW-1:0]] = 1'b1;
        stamp_nxt = stamp_r + 64'd1;
        state_nxt = cla_pkg::S_RESULT;
      end

      cla_pkg::S_TOTAL_SCAN: begin
        if (rd_pend_r) begin
          if (t_valid_r[rd_idx_r[GIW-1:0]]) begin
            if (!hit_r && t_rd.group_id == key_group_r &&
                t_rd.call_number == job_r.item.call_number) begin
              hit_nxt     = 1'b1;
              hit_idx_nxt = rd_idx_r;
              hit_a_nxt   = t_rd.event_count;
              hit_b_nxt   = t_rd.latency_total;
            end
          end else if (!free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = rd_idx_r;
          end
        end
        if (scan_done) begin
          if (job_r.item.op == cla_pkg::OP_READ) begin
            if (hit_r) begin
              res_pend_nxt.call_count  = hit_a_r;
              res_pend_nxt.latency_sum = hit_b_r;
            end else begin
              res_pend_nxt.status = cla_pkg::STAT_MISS;
            end
            state_nxt = cla_pkg::S_RESULT;
          end else begin
            if (!hit_r) begin
              hit_a_nxt = 64'd0;
              hit_b_nxt = 64'd0;
            end
            state_nxt = cla_pkg::S_TOTAL_WR;
          end
        end
      end

      cla_pkg::S_TOTAL_WR: begin
        // add this latency, or drop it when the store is full
        res_pend_nxt.this_latency = lat_r;
        if (hit_r || free_r) begin
          t_we = 1'b1;
          t_valid_nxt[t_waddr] = 1'b1;
          res_pend_nxt.call_count  = hit_a_r + 64'd1;
          res_pend_nxt.latency_sum = hit_b_r + lat_r;
        end else begin
          res_pend_nxt.status = cla_pkg::STAT_FULL;
        end
        state_nxt = cla_pkg::S_RESULT;
      end

      cla_pkg::S_RESULT: begin
        // move the result out once the output register is free
        if (!res_vld_r || out_pop) begin
          res_nxt     = res_pend_r;
          res_vld_nxt = 1'b1;
          state_nxt   = cla_pkg::S_IDLE;
        end
      end

      default: state_nxt = cla_pkg::S_IDLE;
    endcase
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> state_r == cla_pkg::S_IDLE) else $error("job taken while busy");
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_addr_r <= ((S_END > G_END) ? S_END : G_END)) else $error("scan overran store");
  a_wr_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cla_pkg::S_START_WR || state_r == cla_pkg::S_TOTAL_WR)
      |=> state_r == cla_pkg::S_RESULT) else $error("store write not followed by result");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cla_pkg::S_RESULT && res_vld_r && !out_pop) |=> $stable(res_r))
    else $error("result overwritten while waiting");

endmodule
`default_nettype wire

// ----- rtl/core/call_latency_aggregator_core.sv -----
// Per-group, per-call latency monitor: top level tying front end and back end.
// Depends on cla_pkg, cla_front, cla_back.
//
// Usage:
//   Input channel is queue-like: drive in_data and raise in_push; the
//   transaction is taken when in_full is low. Ops are enter, exit and read.
//   Results leave through a queue-like port: out_data is valid while
//   out_empty is low and is taken on out_pop. Every input gives one result.
//   Configuration writes (cfg_valid, always ready) set filter_enable
//   (index 0) and target_group (index 1); write only while idle.
//   The back end scans a store one entry per cycle through the RAM read
//   port: enter scans the start store, exit the start store and then the
//   aggregate store, read the aggregate store; a filtered or unused op
//   scans neither. The back end takes the next job only once the last
//   has left S_RESULT; a two-entry job queue keeps the input open meanwhile.
//   Reset clears the valid bits of both stores, sets filter_enable and
//   clears target_group; no clearing pass is needed. If the receiver
//   stalls, the result waits in the output register, the next job finishes
//   into a holding register, and then the input fills and in_full rises.
`timescale 1ns / 1ps
`default_nettype none
module call_latency_aggregator_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire cla_pkg::in_item_t             in_data,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output cla_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cla_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]                   cfg_data
);

  logic          job_valid, job_pop;
  cla_pkg::job_t job;

  // accept and classify
  cla_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .job_valid(job_valid), .job_pop(job_pop), .job(job)
  );

  // carry out against the stores
  cla_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job_pop(job_pop), .job(job),
    .out_empty(out_empty), .out_pop(out_pop), .out_data(out_data)
  );

endmodule
`default_nettype wire
